>>> rtl/core/mms_pkg.sv
// Shared types and constants for the model matrix stack.
package mms_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int ROW_W  = 64;
  localparam int ELEM_W = 16;
  localparam int ROWS   = 4;
  localparam int ACC_W  = 34;

  localparam logic [1:0] KIND_MUL   = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic ident;
    logic shift;
    logic mac;
    logic clr;
    logic finish;
  } cell_ctl_t;

endpackage

>>> rtl/core/model_matrix_stack.sv
// Top level: 4x4 model matrix held in a chain of row cells, with a saved-matrix stack.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_ready, kind, operand_row0..3 | in
//   out     | out_valid, out_ready, current_row0..3,    | out
//           | underflow, overflow, stack_level          |
//
// Steps after the input transfer: multiply runs four MAC passes, then saturates and
// loads the result; push and pop move one row per cycle through the single-port stack
// RAM, the pop behind a registered read. Clear, empty pop, full push: straight to result.
// One item at a time; the next transfer is taken the cycle after the result loads.
// A stalled result holds the next item in its final state until out_ready.
// Reset sets the matrix to identity and the level to zero; the RAM needs no clearing.
module model_matrix_stack #(
  parameter int STACK_DEPTH = mms_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = mms_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [mms_pkg::ROW_W-1:0] operand_row0,
  input  logic [mms_pkg::ROW_W-1:0] operand_row1,
  input  logic [mms_pkg::ROW_W-1:0] operand_row2,
  input  logic [mms_pkg::ROW_W-1:0] operand_row3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mms_pkg::ROW_W-1:0] current_row0,
  output logic [mms_pkg::ROW_W-1:0] current_row1,
  output logic [mms_pkg::ROW_W-1:0] current_row2,
  output logic [mms_pkg::ROW_W-1:0] current_row3,
  output logic                      underflow,
  output logic                      overflow,
  output logic [4:0]                stack_level
);
  import mms_pkg::*;

  localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_DEPTH = STACK_DEPTH * ROWS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state, state_next;
  logic [2:0]        cnt;
  logic [LVL_W-1:0]  level;
  logic [SLOT_W-1:0] slot;
  logic              under_r, over_r;
  logic              accept, out_load;
  logic [ROW_W-1:0]  op [ROWS];
  logic [ROW_W-1:0]  rows [ROWS];
  logic [ROW_W-1:0]  chain_in;
  cell_ctl_t         ctl;

  logic [ROW_W-1:0]  mem [MEM_DEPTH];
  logic [ROW_W-1:0]  mem_rdata;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic [1:0]        row_sel;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  assign row_sel  = 2'(2'd3 - cnt[1:0]);
  assign mem_addr = MEM_AW'({slot, row_sel});
  assign mem_we   = (state == S_PUSH);
  assign chain_in = (state == S_POP) ? mem_rdata : rows[ROWS-1];

  always_comb begin
    ctl        = '0;
    ctl.ident  = accept && (kind == KIND_POP) && (level == '0);
    ctl.shift  = (state == S_PUSH) || ((state == S_POP) && (cnt != 3'd0));
    ctl.mac    = (state == S_MUL) && (cnt != 3'd4);
    ctl.clr    = (cnt == 3'd0);
    ctl.finish = (state == S_MUL) && (cnt == 3'd4);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_MUL:   state_next = S_MUL;
            KIND_PUSH:  state_next = (level >= LVL_W'(STACK_DEPTH)) ? S_FIN : S_PUSH;
            KIND_POP:   state_next = (level == '0) ? S_FIN : S_POP;
            KIND_CLEAR: state_next = S_FIN;
            default:    state_next = S_FIN;
          endcase
        end
      end
      S_MUL:   if (cnt == 3'd4) state_next = S_FIN;
      S_PUSH:  if (cnt == 3'd3) state_next = S_FIN;
      S_POP:   if (cnt == 3'd4) state_next = S_FIN;
      S_FIN:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next == state && state != S_IDLE) ? 3'(cnt + 3'd1) : 3'd0;
      if (accept) begin
        unique case (kind)
          KIND_PUSH:  if (level < LVL_W'(STACK_DEPTH)) level <= LVL_W'(level + 1'b1);
          KIND_POP:   if (level != '0) level <= LVL_W'(level - 1'b1);
          KIND_CLEAR: level <= '0;
          default:    level <= level;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op[0]   <= operand_row0;
      op[1]   <= operand_row1;
      op[2]   <= operand_row2;
      op[3]   <= operand_row3;
      under_r <= (kind == KIND_POP) && (level == '0);
      over_r  <= (kind == KIND_PUSH) && (level >= LVL_W'(STACK_DEPTH));
      slot    <= (kind == KIND_PUSH) ? SLOT_W'(level) : SLOT_W'(level - 1'b1);
    end else if (ctl.mac) begin
      for (int i = 0; i < ROWS - 1; i++) begin
        op[i] <= op[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= rows[ROWS-1];
    end
    mem_rdata <= mem[mem_addr];
  end

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    mms_cell #(
      .FRAC_BITS (FRAC_BITS),
      .ROW_IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .row_in  ((i == 0) ? chain_in : rows[(i == 0) ? 0 : i-1]),
      .op_row  (op[0]),
      .row_out (rows[i])
    );
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_row0 <= rows[0];
      current_row1 <= rows[1];
      current_row2 <= rows[2];
      current_row3 <= rows[3];
      underflow    <= under_r;
      overflow     <= over_r;
      stack_level  <= 5'(level);
    end
  end

endmodule

>>> rtl/core/mms_cell.sv
// One row cell: holds a matrix row, shifts it along the chain, multiply-accumulates.
module mms_cell #(
  parameter int FRAC_BITS = mms_pkg::FRAC_BITS_DEF,
  parameter int ROW_IDX   = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mms_pkg::cell_ctl_t        ctl,
  input  logic [mms_pkg::ROW_W-1:0] row_in,
  input  logic [mms_pkg::ROW_W-1:0] op_row,
  output logic [mms_pkg::ROW_W-1:0] row_out
);
  import mms_pkg::*;

  localparam logic [ROW_W-1:0] IDENT = ROW_W'(1) << (FRAC_BITS + ELEM_W * ROW_IDX);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

  logic [ROW_W-1:0]        row;
  logic signed [ACC_W-1:0] acc [ROWS];
  logic signed [ACC_W-1:0] sum [ROWS];
  logic signed [ELEM_W-1:0] elem;
  logic signed [ELEM_W-1:0] opel [ROWS];
  logic signed [2*ELEM_W-1:0] prod [ROWS];
  logic signed [2*ELEM_W-1:0] trunc [ROWS];
  logic [ROW_W-1:0]        sat_row;

  assign elem    = signed'(row[ELEM_W-1:0]);
  assign row_out = row;

  always_comb begin
    for (int c = 0; c < ROWS; c++) begin
      opel[c]  = signed'(op_row[ELEM_W*c +: ELEM_W]);
      prod[c]  = elem * opel[c];
      trunc[c] = prod[c] >>> FRAC_BITS;
      sum[c]   = (ctl.clr ? ACC_W'(0) : acc[c]) + ACC_W'(trunc[c]);
      if (acc[c] > SAT_MAX) begin
        sat_row[ELEM_W*c +: ELEM_W] = 16'h7fff;
      end else if (acc[c] < SAT_MIN) begin
        sat_row[ELEM_W*c +: ELEM_W] = 16'h8000;
      end else begin
        sat_row[ELEM_W*c +: ELEM_W] = acc[c][ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= IDENT;
    end else if (ctl.ident) begin
      row <= IDENT;
    end else if (ctl.shift) begin
      row <= row_in;
    end else if (ctl.mac) begin
      row <= {row[ELEM_W-1:0], row[ROW_W-1:ELEM_W]};
    end else if (ctl.finish) begin
      row <= sat_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mac) begin
      for (int c = 0; c < ROWS; c++) begin
        acc[c] <= sum[c];
      end
    end
  end

endmodule

>>> rtl/core/mms_checker.sv
// Port-level assertions for the model matrix stack, bound to the top level.
module mms_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mms_pkg::ROW_W-1:0] current_row0,
  input logic                      underflow,
  input logic                      overflow,
  input logic [4:0]                stack_level
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_row0) && $stable(stack_level))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transfer taken while busy");

  a_under_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && underflow |-> stack_level == 5'd0)
    else $error("underflow with nonzero level");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(underflow && overflow))
    else $error("both flags set");

endmodule

bind model_matrix_stack mms_checker u_mms_checker (.*);
